// ----- rtl/dpe_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Drawer position estimator package
// Shared types and constants for the drawer position estimator.
// ----------------------------------------------------------------------------
package dpe_pkg;

  // Fixed payload widths.
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned GAIN_W    = 16;
  localparam int unsigned SPEED_W   = 16;
  localparam int unsigned NORM_W    = 8;
  localparam int unsigned CFG_IDX_W = 8;

  // Largest normalized position.
  localparam logic [DATA_W-1:0] NORM_MAX = 32'd255;

  // Reciprocal of 255: a 32-bit value times RECIP_255, shifted right by
  // RECIP_SHIFT, gives the exact quotient by 255.
  localparam logic [DATA_W-1:0] RECIP_255   = 32'h8080_8081;
  localparam int unsigned       RECIP_SHIFT = 39;

  // Operation codes carried by an input item.
  typedef enum logic [1:0] {
    OP_UPDATE       = 2'd0,
    OP_START_MOVE   = 2'd1,
    OP_SET_POSITION = 2'd2,
    OP_CONVERT      = 2'd3
  } op_t;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_USE_ENCODER   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_GAIN = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ENC_EXTENT    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OL_EXTENT     = 8'd3;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_DIV1_GO,
    S_DIV1_WAIT,
    S_APPLY,
    S_NORM_GO,
    S_NORM_WAIT,
    S_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic prep;
    logic div1_start;
    logic apply;
    logic norm_start;
    logic emit;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_div1;
    logic div_done;
    logic out_free;
  } ctrl_stat_t;

endpackage

// ----- rtl/dpe_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Drawer position estimator channels
// Input, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------

// Input item channel.
interface dpe_in_if import dpe_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               operation;
  logic [DATA_W-1:0]        now_ms;
  logic [SPEED_W-1:0]       speed;
  logic signed [DATA_W-1:0] encoder_count;
  logic                     moving_out;
  logic signed [DATA_W-1:0] position_value;

  modport source (
    output valid, operation, now_ms, speed, encoder_count, moving_out, position_value,
    input  ready
  );
  modport sink (
    input  valid, operation, now_ms, speed, encoder_count, moving_out, position_value,
    output ready
  );
endinterface

// Result item channel.
interface dpe_out_if import dpe_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] position;
  logic [NORM_W-1:0]        normed_position;
  logic [DATA_W-1:0]        scaled_position;
  logic                     counter_load;
  logic signed [DATA_W-1:0] counter_value;

  modport source (
    output valid, position, normed_position, scaled_position, counter_load, counter_value,
    input  ready
  );
  modport sink (
    input  valid, position, normed_position, scaled_position, counter_load, counter_value,
    output ready
  );
endinterface

// Configuration write channel.
interface dpe_cfg_if import dpe_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/drawer_position_estimator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Drawer position estimator
// Tracks a drawer position by encoder counts or open-loop integration.
// ----------------------------------------------------------------------------
// Usage:
//   cfg takes register writes (encoder mode select, integral_gain, encoder
//   and open-loop extents) at any time the block is idle; cfg.ready is always
//   high. req carries one operation per item: update, start move, set
//   position or convert byte to counts. rsp returns exactly one item per
//   request with the position, its 0-255 normalized form, the convert
//   result and an optional encoder counter load request.
//   One item is worked on at a time. Every item runs one division for
//   normalization; open-loop updates run a second one first, both on the
//   single shared bit-serial divider. No new item is taken before the
//   result of the last one enters the output register; a new item is
//   taken the cycle after the result enters it, so a stalled result does
//   not block the next item until its own result is ready. Reset clears
//   the drawer state to zero and loads the register reset values.
// ----------------------------------------------------------------------------
module drawer_position_estimator import dpe_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  dpe_cfg_if.sink  cfg,
  dpe_in_if.sink   req,
  dpe_out_if.source rsp
);

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;
  logic       in_ready;
  logic       cfg_we;

  assign cfg.ready = 1'b1;
  assign cfg_we    = cfg.valid && cfg.ready;
  assign req.ready = in_ready;

  // Sequencer.
  dpe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Arithmetic and state.
  dpe_dp u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg.index),
    .cfg_data            (cfg.data),
    .in_operation        (req.operation),
    .in_now_ms           (req.now_ms),
    .in_speed            (req.speed),
    .in_encoder_count    (req.encoder_count),
    .in_moving_out       (req.moving_out),
    .in_position_value   (req.position_value),
    .out_valid           (rsp.valid),
    .out_ready           (rsp.ready),
    .out_position        (rsp.position),
    .out_normed_position (rsp.normed_position),
    .out_scaled_position (rsp.scaled_position),
    .out_counter_load    (rsp.counter_load),
    .out_counter_value   (rsp.counter_value),
    .cmd                 (cmd),
    .stat                (stat)
  );

`ifndef NO_ASSERTIONS
  // An accepted item keeps the input closed while it is worked on.
  assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("input accepted twice in a row");

  // A result is written only into a free output register.
  assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> stat.out_free)
    else $error("result overwrote a pending item");

  // Without a load request the counter value is zero.
  assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.counter_load |-> rsp.counter_value == '0)
    else $error("counter value set without load request");

  // A new result follows an emit command, which comes after a finished normalization division.
  assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(cmd.emit))
    else $error("result appeared without emit");
`endif

endmodule

// ----- rtl/dpe_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Drawer position estimator divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dpe_div import dpe_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DATA_W-1:0] dividend,
  input  logic [DATA_W-1:0] divisor,
  output logic [DATA_W-1:0] quotient,
  output logic              done
);

  localparam int unsigned CNT_W = $clog2(DATA_W);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] quo;
  logic [DATA_W-1:0] dsr;
  logic [DATA_W:0]   shifted;
  logic [DATA_W:0]   trial;

  // One trial subtraction of the shifted remainder.
  always_comb begin
    shifted = {rem, quo[DATA_W-1]};
    trial   = shifted - {1'b0, dsr};
  end

  // Control: count the quotient bits of one division.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == '0);
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DATA_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
        end
        cnt <= cnt - CNT_W'(1);
      end
    end
  end

  // Datapath: remainder and quotient shift registers.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      if (!trial[DATA_W]) begin
        rem <= trial[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b1};
      end else begin
        rem <= shifted[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b0};
      end
    end
  end

  assign quotient = quo;

endmodule

// ----- rtl/dpe_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Drawer position estimator controller
// Sequences one item through product, an optional division, state update and
// normalization, then writes its result.
// ----------------------------------------------------------------------------
module dpe_ctrl import dpe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  ctrl_stat_t stat,
  output ctrl_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        state_next = stat.need_div1 ? S_DIV1_GO : S_APPLY;
      end
      S_DIV1_GO: begin
        state_next = S_DIV1_WAIT;
      end
      S_DIV1_WAIT: begin
        if (stat.div_done) begin
          state_next = S_APPLY;
        end
      end
      S_APPLY: begin
        state_next = S_NORM_GO;
      end
      S_NORM_GO: begin
        state_next = S_NORM_WAIT;
      end
      S_NORM_WAIT: begin
        if (stat.div_done) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_PREP: begin
        cmd.prep = 1'b1;
      end
      S_DIV1_GO: begin
        cmd.div1_start = 1'b1;
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
      end
      S_NORM_GO: begin
        cmd.norm_start = 1'b1;
      end
      S_EMIT: begin
        cmd.emit = stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ----- rtl/dpe_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Drawer position estimator datapath
// Configuration registers, drawer state, multiplier, shared divider and the
// result register.
// ----------------------------------------------------------------------------
module dpe_dp import dpe_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  // Configuration writes.
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [DATA_W-1:0]        cfg_data,
  // Input item payload.
  input  logic [1:0]               in_operation,
  input  logic [DATA_W-1:0]        in_now_ms,
  input  logic [SPEED_W-1:0]       in_speed,
  input  logic [DATA_W-1:0]        in_encoder_count,
  input  logic                     in_moving_out,
  input  logic [DATA_W-1:0]        in_position_value,
  // Result item.
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [DATA_W-1:0]        out_position,
  output logic [NORM_W-1:0]        out_normed_position,
  output logic [DATA_W-1:0]        out_scaled_position,
  output logic                     out_counter_load,
  output logic [DATA_W-1:0]        out_counter_value,
  // Controller link.
  input  ctrl_cmd_t                cmd,
  output ctrl_stat_t               stat
);

  // Configuration registers.
  logic              enc_mode;
  logic [GAIN_W-1:0] integral_gain;
  logic [DATA_W-1:0] encoder_max_extent;
  logic [DATA_W-1:0] open_loop_max_extent;

  // Drawer state.
  logic [DATA_W-1:0] drawer_position;
  logic [DATA_W-1:0] last_time;
  logic              direction_out;

  // Captured item.
  op_t                op;
  logic [DATA_W-1:0]  now_ms;
  logic [SPEED_W-1:0] speed;
  logic [DATA_W-1:0]  encoder_count;
  logic               moving_out;
  logic [DATA_W-1:0]  position_value;

  // Intermediate results.
  logic [DATA_W-1:0] product;
  logic [DATA_W-1:0] scaled;
  logic              load;
  logic [DATA_W-1:0] load_value;

  // Combinational helpers.
  logic [DATA_W-1:0]         extent;
  logic [DATA_W-1:0]         mul_a;
  logic [SPEED_W-1:0]        mul_b;
  logic [DATA_W+SPEED_W-1:0] mul_p;
  logic [2*DATA_W-1:0]       recip_p;
  logic [DATA_W-1:0]         recip_q;
  logic [DATA_W-1:0]         div_dividend;
  logic [DATA_W-1:0]         div_divisor;
  logic [DATA_W-1:0]         quotient;
  logic                      div_done;
  logic                      div_start;
  logic [DATA_W-1:0]         neg_count;
  logic [DATA_W-1:0]         increment;
  logic [DATA_W-1:0]         sum;
  logic [DATA_W-1:0]         norm_dividend;
  logic [NORM_W-1:0]         normed;

  // Configuration register writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      enc_mode             <= 1'b0;
      integral_gain        <= GAIN_W'(1);
      encoder_max_extent   <= DATA_W'(1);
      open_loop_max_extent <= DATA_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_USE_ENCODER:   enc_mode             <= cfg_data[0];
        REG_INTEGRAL_GAIN: integral_gain        <= cfg_data[GAIN_W-1:0];
        REG_ENC_EXTENT:    encoder_max_extent   <= cfg_data;
        REG_OL_EXTENT:     open_loop_max_extent <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Active extent, with zero read as one.
  always_comb begin
    extent = enc_mode ? encoder_max_extent : open_loop_max_extent;
    if (extent == '0) begin
      extent = DATA_W'(1);
    end
  end

  // Capture the item payload at acceptance.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op             <= op_t'(in_operation);
      now_ms         <= in_now_ms;
      speed          <= in_speed;
      encoder_count  <= in_encoder_count;
      moving_out     <= in_moving_out;
      position_value <= in_position_value;
    end
  end

  // One multiplier: elapsed time times speed, or byte times extent.
  always_comb begin
    if (op == OP_UPDATE) begin
      mul_a = now_ms - last_time;
      mul_b = speed;
    end else begin
      mul_a = extent;
      mul_b = SPEED_W'(position_value[NORM_W-1:0]);
    end
    mul_p = {{SPEED_W{1'b0}}, mul_a} * {{DATA_W{1'b0}}, mul_b};
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      product <= mul_p[DATA_W-1:0];
    end
  end

  // Conversion quotient by 255 through the reciprocal, exact for any
  // 32-bit product.
  always_comb begin
    recip_p = {{DATA_W{1'b0}}, product} * {{DATA_W{1'b0}}, RECIP_255};
    recip_q = DATA_W'(recip_p[2*DATA_W-1:RECIP_SHIFT]);
  end

  // Divider operand selection: the open-loop increment first, then the
  // normalization of the updated position.
  assign norm_dividend = {drawer_position[DATA_W-NORM_W-1:0], {NORM_W{1'b0}}}
                         - drawer_position;

  always_comb begin
    if (cmd.norm_start) begin
      div_dividend = norm_dividend;
      div_divisor  = extent;
    end else begin
      div_dividend = product;
      if (integral_gain == '0) begin
        div_divisor = DATA_W'(1);
      end else begin
        div_divisor = DATA_W'(integral_gain);
      end
    end
  end

  assign div_start = cmd.div1_start || cmd.norm_start;

  dpe_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (quotient),
    .done     (div_done)
  );

  // Position arithmetic for the update operation.
  always_comb begin
    neg_count = '0 - encoder_count;
    increment = direction_out ? quotient : ('0 - quotient);
    sum       = drawer_position + increment;
  end

  // Apply the operation to the drawer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      drawer_position <= '0;
      last_time       <= '0;
      direction_out   <= 1'b0;
    end else if (cmd.apply) begin
      case (op)
        OP_UPDATE: begin
          if (enc_mode) begin
            drawer_position <= neg_count[DATA_W-1] ? '0 : neg_count;
          end else begin
            drawer_position <= sum[DATA_W-1] ? '0 : sum;
            last_time       <= now_ms;
          end
        end
        OP_START_MOVE: begin
          direction_out <= moving_out;
          if (!enc_mode) begin
            last_time <= now_ms;
          end
        end
        OP_SET_POSITION: begin
          drawer_position <= position_value;
        end
        default: begin
        end
      endcase
    end
  end

  // Side results of the operation.
  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      scaled     <= (op == OP_CONVERT) ? recip_q : '0;
      load       <= 1'b0;
      load_value <= '0;
      if (op == OP_UPDATE && enc_mode && neg_count[DATA_W-1]) begin
        load <= 1'b1;
      end
      if (op == OP_SET_POSITION && enc_mode) begin
        load       <= 1'b1;
        load_value <= position_value;
      end
    end
  end

  // Normalized position, saturated.
  assign normed = (quotient > NORM_MAX) ? NORM_MAX[NORM_W-1:0] : quotient[NORM_W-1:0];

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_position        <= drawer_position;
      out_normed_position <= normed;
      out_scaled_position <= scaled;
      out_counter_load    <= load;
      out_counter_value   <= load_value;
    end
  end

  // Status to the controller.
  always_comb begin
    stat.need_div1 = (op == OP_UPDATE) && !enc_mode;
    stat.div_done  = div_done;
    stat.out_free  = !out_valid || out_ready;
  end

endmodule
